// File: src/quadratic_form_coordinate_update_core_assert.svh
// Assertion helpers for the quadratic form update core.
`ifndef QUADRATIC_FORM_COORDINATE_UPDATE_CORE_ASSERT_SVH
`define QUADRATIC_FORM_COORDINATE_UPDATE_CORE_ASSERT_SVH

// Same-cycle implication, disabled in reset.
`define QFCU_ASSERT_IMPLY(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, disabled in reset.
`define QFCU_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// File: src/qfcu_pkg.sv
package qfcu_pkg;

   localparam int DIM_W  = 5;
   localparam int DATA_W = 32;

   localparam logic [1:0] MODE_LOAD_MATRIX = 2'd0;
   localparam logic [1:0] MODE_LOAD_CACHE  = 2'd1;
   localparam logic [1:0] MODE_MOVE        = 2'd2;
   localparam logic [1:0] MODE_READ        = 2'd3;

   localparam logic [DIM_W-1:0] DIM_RESET = 5'd16;

   typedef struct packed {
      logic [1:0]               mode;
      logic [4:0]               first_index;
      logic [3:0]               second_index;
      logic signed [DATA_W-1:0] load_value;
      logic signed [DATA_W-1:0] step;
   } req_type;

   typedef struct packed {
      logic signed [DATA_W-1:0] read_value;
      logic signed [DATA_W-1:0] quad_term;
      logic                     status;
   } rsp_type;

   // clamp a 64-bit sum to the signed 32-bit range
   function automatic logic signed [DATA_W-1:0] sat32(input logic signed [63:0] v);
      logic signed [DATA_W-1:0] r;
      if (v > 64'sd2147483647) begin
         r = 32'sh7fffffff;
      end else if (v < -64'sd2147483648) begin
         r = 32'sh80000000;
      end else begin
         r = v[DATA_W-1:0];
      end
      return r;
   endfunction

endpackage

// File: src/quadratic_form_coordinate_update_core.sv
// Loads and reads: the item goes through the finishing step to the output register; the next
// item is taken once the block is back in idle. Move: the item steps through A[d][d]*dx, the
// inner sum, dx*s, the quadratic update and a walk over the n cache entries in use (n = dimension
// in use), one cache entry a cycle, with one shared 32x32 multiplier and one read port per memory.
// Reset (synchronous, active high): dimension 16, cache and quadratic term zero,
// matrix contents undefined until loaded; no clearing pass is needed.
`include "quadratic_form_coordinate_update_core_assert.svh"

module quadratic_form_coordinate_update_core #(
   parameter int MAX_DIM   = 16,
   parameter int FRAC_BITS = 16
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_valid,
   output logic                         req_ready,
   input  qfcu_pkg::req_type            req_item,
   output logic                         rsp_valid,
   input  logic                         rsp_ready,
   output qfcu_pkg::rsp_type            rsp_item,
   input  logic                         csr_we,
   input  logic [qfcu_pkg::DIM_W-1:0]   csr_wdata
);
   import qfcu_pkg::*;

   // count width: holds MAX_DIM itself and every index field
   localparam int CW        = ($clog2(MAX_DIM + 1) > DIM_W) ? $clog2(MAX_DIM + 1) : DIM_W;
   localparam int AW        = (MAX_DIM > 1) ? $clog2(MAX_DIM) : 1;
   localparam int MAT_DEPTH = MAX_DIM * MAX_DIM;
   localparam int MW        = (MAT_DEPTH > 1) ? $clog2(MAT_DEPTH) : 1;

   typedef enum logic [6:0] {
      ST_IDLE  = 7'b0000001,
      ST_MULA  = 7'b0000010,  // A[d][d]*dx in the multiplier
      ST_INNER = 7'b0000100,  // s = sat(2*cache[d] + product)
      ST_MULQ  = 7'b0001000,  // dx*s in the multiplier
      ST_QUAD  = 7'b0010000,  // fold product into the quadratic term
      ST_LOOP  = 7'b0100000,  // walk cache[i] += dx*A[i][d]
      ST_FIN   = 7'b1000000   // hand the result to the output register
   } state_type;

   state_type st_ff, st_in;

   logic [DIM_W-1:0]         dim_ff;
   logic signed [DATA_W-1:0] quad_ff;
   logic signed [DATA_W-1:0] dx_ff;
   logic [AW-1:0]            d_ff;
   logic signed [DATA_W-1:0] cd_ff;
   logic signed [DATA_W-1:0] s_ff;
   logic signed [63:0]       prod_ff, prod_in;
   logic [CW-1:0]            iss_ff;
   logic                     s1_vld_ff, s2_vld_ff;
   logic [AW-1:0]            s1_idx_ff, s2_idx_ff;
   logic signed [DATA_W-1:0] cval_ff;
   logic signed [DATA_W-1:0] res_val_ff;
   logic                     res_mem_ff;
   logic                     res_st_ff;
   logic                     rsp_valid_ff;
   rsp_type                  rsp_item_ff;

   // storage
   logic signed [DATA_W-1:0] mat_mem [MAT_DEPTH];
   logic signed [DATA_W-1:0] cache_mem [MAX_DIM];
   logic [MAX_DIM-1:0]       cvld_ff;
   logic signed [DATA_W-1:0] mat_rd_ff, cache_rd_ff;
   logic                     cvld_rd_ff;

   logic [CW-1:0]            n_use;
   logic                     accept, fi_ok, si_ok, fi_quad, iss_go, slot_free, loop_done;
   logic                     mat_we, mat_re, cache_we, cache_re;
   logic [MW-1:0]            mat_waddr, mat_raddr;
   logic [AW-1:0]            cache_waddr, cache_raddr;
   logic signed [DATA_W-1:0] cache_wdata, mul_a, rd_word, rsp_rv;
   logic signed [63:0]       prod_sh, inner_sum, quad_sum, loop_sum;
   logic                     status_in;

   // dimension in use: zero acts as one, anything above the build limit as the limit
   always_comb begin
      if (dim_ff == '0) begin
         n_use = CW'(1);
      end else if (CW'(dim_ff) > CW'(MAX_DIM)) begin
         n_use = CW'(MAX_DIM);
      end else begin
         n_use = CW'(dim_ff);
      end
   end

   assign req_ready = (st_ff == ST_IDLE);
   assign accept    = req_valid && req_ready;
   assign fi_ok     = CW'(req_item.first_index) < n_use;
   assign si_ok     = CW'(req_item.second_index) < n_use;
   assign fi_quad   = CW'(req_item.first_index) == CW'(MAX_DIM);
   assign iss_go    = (st_ff == ST_LOOP) && (iss_ff < n_use);
   assign loop_done = (st_ff == ST_LOOP) && !iss_go && !s1_vld_ff && !s2_vld_ff;
   assign slot_free = !rsp_valid_ff || rsp_ready;

   // one shared multiplier; the product is always registered before use
   assign mul_a     = (st_ff == ST_MULQ) ? s_ff : mat_rd_ff;
   assign prod_in   = mul_a * dx_ff;
   assign prod_sh   = prod_ff >>> FRAC_BITS;
   assign rd_word   = cvld_rd_ff ? cache_rd_ff : '0;
   assign inner_sum = $signed({{31{cd_ff[DATA_W-1]}}, cd_ff, 1'b0}) + prod_sh;
   assign quad_sum  = 64'(quad_ff) + prod_sh;
   assign loop_sum  = 64'(cval_ff) + prod_sh;

   // memory ports
   assign mat_we    = accept && (req_item.mode == MODE_LOAD_MATRIX) && fi_ok && si_ok;
   assign mat_waddr = MW'(AW'(req_item.first_index)) * MW'(MAX_DIM)
                      + MW'(AW'(req_item.second_index));
   assign mat_re    = iss_go || (accept && (req_item.mode == MODE_MOVE) && si_ok);
   assign mat_raddr = (st_ff == ST_LOOP)
                      ? MW'(AW'(iss_ff)) * MW'(MAX_DIM) + MW'(d_ff)
                      : MW'(AW'(req_item.second_index)) * MW'(MAX_DIM)
                        + MW'(AW'(req_item.second_index));

   assign cache_we    = s2_vld_ff
                        || (accept && (req_item.mode == MODE_LOAD_CACHE) && fi_ok);
   assign cache_waddr = s2_vld_ff ? s2_idx_ff : AW'(req_item.first_index);
   assign cache_wdata = s2_vld_ff ? sat32(loop_sum) : req_item.load_value;
   assign cache_re    = iss_go
                        || (accept && (((req_item.mode == MODE_MOVE) && si_ok)
                                       || ((req_item.mode == MODE_READ) && fi_ok)));
   always_comb begin
      if (st_ff == ST_LOOP) begin
         cache_raddr = AW'(iss_ff);
      end else if (req_item.mode == MODE_MOVE) begin
         cache_raddr = AW'(req_item.second_index);
      end else begin
         cache_raddr = AW'(req_item.first_index);
      end
   end

   always_ff @(posedge clock) begin
      if (mat_we) begin
         mat_mem[mat_waddr] <= req_item.load_value;
      end
      if (mat_re) begin
         mat_rd_ff <= mat_mem[mat_raddr];
      end
   end

   always_ff @(posedge clock) begin
      if (cache_we) begin
         cache_mem[cache_waddr] <= cache_wdata;
      end
      if (cache_re) begin
         cache_rd_ff <= cache_mem[cache_raddr];
      end
   end

   // entry valid bits stand in for clearing the cache: an unwritten entry reads zero
   always_ff @(posedge clock) begin
      if (reset) begin
         cvld_ff    <= '0;
         cvld_rd_ff <= 1'b0;
      end else begin
         if (cache_we) begin
            cvld_ff[cache_waddr] <= 1'b1;
         end
         if (cache_re) begin
            cvld_rd_ff <= cvld_ff[cache_raddr];
         end
      end
   end

   // status for the item being taken
   always_comb begin
      case (req_item.mode)
         MODE_LOAD_MATRIX: status_in = !(fi_ok && si_ok);
         MODE_LOAD_CACHE:  status_in = !(fi_ok || fi_quad);
         MODE_READ:        status_in = !(fi_ok || fi_quad);
         MODE_MOVE:        status_in = !si_ok;
         default:          status_in = 1'b1;
      endcase
   end

   // sequencer
   always_comb begin
      st_in = st_ff;
      case (st_ff)
         ST_IDLE: begin
            if (accept) begin
               st_in = ((req_item.mode == MODE_MOVE) && si_ok) ? ST_MULA : ST_FIN;
            end
         end
         ST_MULA:  st_in = ST_INNER;
         ST_INNER: st_in = ST_MULQ;
         ST_MULQ:  st_in = ST_QUAD;
         ST_QUAD:  st_in = ST_LOOP;
         ST_LOOP: begin
            if (loop_done) begin
               st_in = ST_FIN;
            end
         end
         ST_FIN: begin
            if (slot_free) begin
               st_in = ST_IDLE;
            end
         end
         default: st_in = ST_IDLE;
      endcase
   end

   // read value handed out at the end of the item
   assign rsp_rv = res_mem_ff ? rd_word : res_val_ff;

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff        <= ST_IDLE;
         dim_ff       <= DIM_RESET;
         quad_ff      <= '0;
         s1_vld_ff    <= 1'b0;
         s2_vld_ff    <= 1'b0;
         iss_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         st_ff <= st_in;
         if (csr_we) begin
            dim_ff <= csr_wdata;
         end
         // quadratic term: direct load of its slot, or the move update
         if (accept && (req_item.mode == MODE_LOAD_CACHE) && fi_quad) begin
            quad_ff <= req_item.load_value;
         end else if (st_ff == ST_QUAD) begin
            quad_ff <= sat32(quad_sum);
         end
         // loop issue counter and the two stages behind it
         if (st_ff == ST_QUAD) begin
            iss_ff <= '0;
         end else if (iss_go) begin
            iss_ff <= iss_ff + CW'(1);
         end
         s1_vld_ff <= iss_go;
         s2_vld_ff <= s1_vld_ff;
         // output register: load at the end of an item, drop when taken
         if ((st_ff == ST_FIN) && slot_free) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      prod_ff   <= prod_in;
      s1_idx_ff <= AW'(iss_ff);
      s2_idx_ff <= s1_idx_ff;
      cval_ff   <= rd_word;
      if (accept) begin
         dx_ff      <= req_item.step;
         d_ff       <= AW'(req_item.second_index);
         res_st_ff  <= status_in;
         res_mem_ff <= (req_item.mode == MODE_READ) && fi_ok;
         if ((req_item.mode == MODE_READ) && fi_quad) begin
            res_val_ff <= quad_ff;
         end else begin
            res_val_ff <= '0;
         end
      end
      if (st_ff == ST_MULA) begin
         cd_ff <= rd_word;
      end
      if (st_ff == ST_INNER) begin
         s_ff <= sat32(inner_sum);
      end
      if ((st_ff == ST_FIN) && slot_free) begin
         rsp_item_ff.read_value <= rsp_rv;
         rsp_item_ff.quad_term  <= quad_ff;
         rsp_item_ff.status     <= res_st_ff;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_item  = rsp_item_ff;

   // a new item never overlaps loop stages still in flight
   `QFCU_ASSERT_IMPLY(a_accept_quiet, clock, reset, accept, !s1_vld_ff && !s2_vld_ff, "item taken while loop busy")
   // loop write-back stays inside the dimension in use
   `QFCU_ASSERT_IMPLY(a_wb_range, clock, reset, s2_vld_ff, (st_ff == ST_LOOP) && (CW'(s2_idx_ff) < n_use), "loop write-back out of range")
   // a result only appears after the finishing step
   `QFCU_ASSERT_IMPLY(a_rsp_from_fin, clock, reset, $rose(rsp_valid_ff), $past(st_ff == ST_FIN), "result without finishing step")
   // the quadratic step always enters the cache walk
   `QFCU_ASSERT_NEXT(a_quad_to_loop, clock, reset, st_ff == ST_QUAD, (st_ff == ST_LOOP) && (iss_ff == '0), "cache walk not started")

endmodule

// File: tb/tb.sv
`timescale 1ns / 100ps

module tb;
   import qfcu_pkg::*;

   localparam int MAX_DIM          = 16;
   localparam int FRAC_BITS        = 16;
   localparam int QUAD_SLOT        = MAX_DIM;
   localparam int SETTLE_CYCLES    = MAX_DIM + 12;
   localparam int LONG_HOLD_CYCLES = 200;
   localparam int CYCLE_LIMIT      = 300000;
   localparam int PHASE_ITEMS      = 50;

   localparam logic signed [63:0] Q_MAX = 64'sd2147483647;
   localparam logic signed [63:0] Q_MIN = -64'sd2147483648;

   logic    clock;
   logic    reset     = 1'b1;
   logic    req_valid = 1'b0;
   logic    req_ready;
   req_type req_item  = '0;
   logic    rsp_valid;
   logic    rsp_ready = 1'b0;
   rsp_type rsp_item;
   logic    csr_we    = 1'b0;
   logic [DIM_W-1:0] csr_wdata = '0;

   // Shadow copy of the block state, updated as each item is accepted.
   logic signed [31:0] form_matrix [0:MAX_DIM-1][0:MAX_DIM-1];
   logic signed [31:0] form_cache [0:MAX_DIM] = '{default: '0};
   bit                 entry_loaded [0:MAX_DIM-1][0:MAX_DIM-1];
   logic [DIM_W-1:0]   dim_setting = DIM_RESET;

   rsp_type form_results_due [$];

   bit sender_idles   = 1'b1;
   bit receiver_idles = 1'b1;
   bit rsp_hold_long  = 1'b0;

   int mismatches      = 0;
   int results_checked = 0;
   int cycle_count     = 0;
   int moves_applied   = 0;
   int loads_applied   = 0;
   int reads_applied   = 0;
   int items_rejected  = 0;
   int dim_writes      = 0;
   int long_holds      = 0;

   quadratic_form_coordinate_update_core #(
      .MAX_DIM   (MAX_DIM),
      .FRAC_BITS (FRAC_BITS)
   ) u_top (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_item  (req_item),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_item  (rsp_item),
      .csr_we    (csr_we),
      .csr_wdata (csr_wdata)
   );

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   // Bound the run; a hang anywhere ends here.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("timeout after %0d cycles, %0d results outstanding",
                  cycle_count, form_results_due.size());
         $display("tb NOT OK");
         $finish;
      end
   end

   // ---------------------------------------------------------------------
   // Fixed-point arithmetic of the block
   // ---------------------------------------------------------------------

   // Exact 64-bit product, then floor shift back to Q16.16 (no clamp here).
   function automatic logic signed [63:0] fx_mul(input logic signed [31:0] a,
                                                 input logic signed [31:0] b);
      logic signed [63:0] wa;
      logic signed [63:0] wb;
      wa = 64'(a);
      wb = 64'(b);
      return (wa * wb) >>> FRAC_BITS;
   endfunction

   function automatic logic signed [31:0] clamp_q32(input logic signed [63:0] v);
      if (v > Q_MAX) return Q_MAX[31:0];
      if (v < Q_MIN) return Q_MIN[31:0];
      return v[31:0];
   endfunction

   // Zero behaves as one, anything past the built size as the built size.
   function automatic int unsigned active_dim();
      if (dim_setting == 0) return 1;
      if (dim_setting > MAX_DIM) return MAX_DIM;
      return 32'(dim_setting);
   endfunction

   // Apply one accepted item to the shadow state and return its result.
   function automatic rsp_type compute_form_update(input req_type it);
      rsp_type            r;
      int unsigned        n;
      logic               cache_ok;
      logic [3:0]         d;
      logic signed [31:0] dx;
      logic signed [31:0] s;
      logic signed [63:0] wide;
      n        = active_dim();
      cache_ok = (it.first_index < n) || (it.first_index == QUAD_SLOT);
      d        = it.second_index;
      dx       = it.step;
      r.read_value = '0;
      r.status     = 1'b0;
      case (it.mode)
         MODE_LOAD_MATRIX: begin
            if (it.first_index < n && it.second_index < n) begin
               form_matrix[it.first_index][it.second_index]  = it.load_value;
               entry_loaded[it.first_index][it.second_index] = 1'b1;
               loads_applied++;
            end else begin
               r.status = 1'b1;
            end
         end
         MODE_LOAD_CACHE: begin
            if (cache_ok) begin
               form_cache[it.first_index] = it.load_value;
               loads_applied++;
            end else begin
               r.status = 1'b1;
            end
         end
         MODE_READ: begin
            if (cache_ok) begin
               r.read_value = form_cache[it.first_index];
               reads_applied++;
            end else begin
               r.status = 1'b1;
            end
         end
         default: begin
            if (d < n) begin
               // quadratic term first, from the cache entry before it moves
               wide = 64'(form_cache[d]);
               s    = clamp_q32(2 * wide + fx_mul(form_matrix[d][d], dx));
               wide = 64'(form_cache[QUAD_SLOT]);
               form_cache[QUAD_SLOT] = clamp_q32(wide + fx_mul(dx, s));
               for (int i = 0; i < n; i++) begin
                  wide          = 64'(form_cache[i]);
                  form_cache[i] = clamp_q32(wide + fx_mul(dx, form_matrix[i][d]));
               end
               moves_applied++;
            end else begin
               r.status = 1'b1;
            end
         end
      endcase
      if (r.status) items_rejected++;
      r.quad_term = form_cache[QUAD_SLOT];
      return r;
   endfunction

   // ---------------------------------------------------------------------
   // Stimulus helpers
   // ---------------------------------------------------------------------

   function automatic req_type make_req(input logic [1:0] mode,
                                        input logic [4:0] fi,
                                        input logic [3:0] si,
                                        input logic signed [31:0] lv,
                                        input logic signed [31:0] st);
      req_type it;
      it.mode         = mode;
      it.first_index  = fi;
      it.second_index = si;
      it.load_value   = lv;
      it.step         = st;
      return it;
   endfunction

   // Mostly small magnitudes so sums do not pin at the rails, plus
   // wide values and the extremes.
   function automatic logic signed [31:0] rand_q16();
      int unsigned        k;
      logic signed [31:0] v;
      k = $urandom_range(0, 19);
      if (k < 10) begin
         v = $signed($urandom_range(0, 32'h0008_0000)) - 32'sh0004_0000;
      end else if (k < 14) begin
         v = $signed($urandom()) >>> 8;
      end else if (k < 17) begin
         v = $signed($urandom());
      end else begin
         case ($urandom_range(0, 4))
            0:       v = 32'sh7fff_ffff;
            1:       v = 32'sh8000_0000;
            2:       v = '0;
            3:       v = -32'sh0001_0000;
            default: v = 32'sh0000_ffff;
         endcase
      end
      return v;
   endfunction

   // Cache slot: usually in range, sometimes the quadratic slot or anything.
   function automatic logic [4:0] rand_cache_index(input int unsigned n);
      int unsigned k;
      k = $urandom_range(0, 19);
      if (k < 3) return 5'($urandom_range(0, 31));
      if (k < 6) return 5'(QUAD_SLOT);
      return 5'($urandom_range(0, n - 1));
   endfunction

   // An in-range move is only issued once its whole column is loaded for the current
   // dimension; until then the move turns into a load of a missing entry.
   function automatic req_type random_form_item();
      req_type     it;
      int unsigned n;
      int unsigned pick;
      int          hole;
      n    = active_dim();
      pick = $urandom_range(0, 99);
      it   = make_req(MODE_MOVE, 5'($urandom_range(0, 31)), 4'($urandom_range(0, 15)),
                      rand_q16(), rand_q16());
      if (pick < 25) begin
         it.mode = MODE_LOAD_MATRIX;
         if ($urandom_range(0, 9) != 0) begin
            it.first_index  = 5'($urandom_range(0, n - 1));
            it.second_index = 4'($urandom_range(0, n - 1));
         end
      end else if (pick < 37) begin
         it.mode        = MODE_LOAD_CACHE;
         it.first_index = rand_cache_index(n);
      end else if (pick < 57) begin
         it.mode        = MODE_READ;
         it.first_index = rand_cache_index(n);
      end else begin
         if (n < MAX_DIM && $urandom_range(0, 9) == 0) begin
            it.second_index = 4'($urandom_range(n, MAX_DIM - 1));
         end else begin
            it.second_index = 4'($urandom_range(0, n - 1));
            hole = -1;
            for (int r = 0; r < n; r++) begin
               if (hole < 0 && !entry_loaded[r][it.second_index]) hole = r;
            end
            if (hole >= 0) begin
               it.mode        = MODE_LOAD_MATRIX;
               it.first_index = 5'(hole);
            end
         end
      end
      return it;
   endfunction

   // Offer one item and hold it until taken; predict at the accepting edge.
   task automatic send_item(input req_type it);
      int unsigned gap;
      gap = sender_idles ? $urandom_range(0, 6) : 0;
      if (gap != 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_item  <= it;
      req_valid <= 1'b1;
      do @(posedge clock); while (!req_ready);
      form_results_due.push_back(compute_form_update(it));
   endtask

   task automatic send_random_items(input int count);
      for (int k = 0; k < count; k++) send_item(random_form_item());
   endtask

   // Drop valid and wait for every outstanding result, then let the block settle.
   task automatic wait_drained();
      req_valid <= 1'b0;
      while (form_results_due.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_dimension(input logic [DIM_W-1:0] value);
      wait_drained();
      csr_wdata <= value;
      csr_we    <= 1'b1;
      @(posedge clock);
      csr_we      <= 1'b0;
      dim_setting  = value;
      dim_writes++;
   endtask

   // ---------------------------------------------------------------------
   // Result side
   // ---------------------------------------------------------------------

   task automatic report_mismatch(input string what, input logic [31:0] got,
                                  input logic [31:0] want);
      mismatches++;
      $display("[%0t] mismatch on %s: got %h, expected %h", $time, what, got, want);
   endtask

   // Draw a stall per result; on request, hold off for one long stretch.
   initial begin : result_receiver
      int unsigned stall;
      @(posedge clock);
      forever begin
         if (rsp_hold_long) begin
            rsp_ready <= 1'b0;
            repeat (LONG_HOLD_CYCLES) @(posedge clock);
            rsp_hold_long = 1'b0;
            long_holds++;
         end
         stall = receiver_idles ? $urandom_range(0, 6) : 0;
         if (stall != 0) begin
            rsp_ready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_ready <= 1'b1;
         do @(posedge clock); while (!rsp_valid);
      end
   end

   // Compare each accepted result against the oldest prediction.
   always @(posedge clock) begin : result_check
      rsp_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (form_results_due.size() == 0) begin
            report_mismatch("unexpected result", rsp_item.quad_term, '0);
         end else begin
            want = form_results_due.pop_front();
            results_checked++;
            if (rsp_item.read_value !== want.read_value)
               report_mismatch("read_value", rsp_item.read_value, want.read_value);
            if (rsp_item.quad_term !== want.quad_term)
               report_mismatch("quad_term", rsp_item.quad_term, want.quad_term);
            if (rsp_item.status !== want.status)
               report_mismatch("status", 32'(rsp_item.status), 32'(want.status));
         end
      end
   end

   // ---------------------------------------------------------------------
   // Tests
   // ---------------------------------------------------------------------

   // Reset contents: cache and quadratic term read back zero, bad slots reject.
   task automatic test_reset_state();
      send_item(make_req(MODE_READ, 5'd0, 4'd0, rand_q16(), rand_q16()));
      send_item(make_req(MODE_READ, 5'd16, 4'd15, rand_q16(), rand_q16()));
      send_item(make_req(MODE_READ, 5'd17, 4'd0, rand_q16(), rand_q16()));
      send_item(make_req(MODE_READ, 5'd31, 4'd15, rand_q16(), rand_q16()));
   endtask

   // Small dimension so a full column loads quickly; drive the rails.
   task automatic test_directed_moves();
      write_dimension(5'd2);
      send_item(make_req(MODE_LOAD_MATRIX, 5'd0, 4'd0, 32'sh7fff_ffff, '0));
      send_item(make_req(MODE_LOAD_MATRIX, 5'd1, 4'd0, 32'sh8000_0000, '0));
      send_item(make_req(MODE_LOAD_MATRIX, 5'd0, 4'd1, 32'sh0001_0000, '0));
      send_item(make_req(MODE_LOAD_MATRIX, 5'd1, 4'd1, -32'sh0001_0000, '0));
      send_item(make_req(MODE_LOAD_CACHE, 5'd0, 4'd0, 32'sh7fff_ffff, '0));
      send_item(make_req(MODE_LOAD_CACHE, 5'd1, 4'd0, 32'sh8000_0000, '0));
      // first_index is a don't-care for moves
      send_item(make_req(MODE_MOVE, 5'd31, 4'd0, '0, 32'sh0001_0000));
      send_item(make_req(MODE_MOVE, 5'd0, 4'd1, '0, 32'sh8000_0000));
      send_item(make_req(MODE_MOVE, 5'd7, 4'd0, '0, 32'sh7fff_ffff));
      // a tiny negative step checks the floor on the shift
      send_item(make_req(MODE_MOVE, 5'd0, 4'd1, '0, -32'sd1));
      send_item(make_req(MODE_MOVE, 5'd0, 4'd2, '0, 32'sh0001_0000));
      send_item(make_req(MODE_LOAD_MATRIX, 5'd2, 4'd0, 32'sh0000_1234, '0));
      send_item(make_req(MODE_LOAD_CACHE, 5'd2, 4'd0, 32'sh0000_5678, '0));
      send_item(make_req(MODE_READ, 5'd1, 4'd0, '0, '0));
      send_item(make_req(MODE_READ, 5'd16, 4'd0, '0, '0));
   endtask

   // Dimension zero acts as one; values past the built size act as the size.
   task automatic test_dimension_limits();
      write_dimension(5'd0);
      send_item(make_req(MODE_LOAD_MATRIX, 5'd0, 4'd0, 32'sh0002_0000, '0));
      send_item(make_req(MODE_MOVE, 5'd0, 4'd0, '0, 32'sh0000_8000));
      send_item(make_req(MODE_MOVE, 5'd0, 4'd1, '0, 32'sh0000_8000));
      send_item(make_req(MODE_READ, 5'd1, 4'd0, '0, '0));
      send_item(make_req(MODE_READ, 5'd16, 4'd0, '0, '0));
      write_dimension(5'd31);
      send_item(make_req(MODE_READ, 5'd15, 4'd0, '0, '0));
      send_item(make_req(MODE_READ, 5'd17, 4'd0, '0, '0));
   endtask

   // Hold results off for a long stretch while items keep coming, so the
   // block backs up and stalls its input.
   task automatic test_result_backpressure();
      write_dimension(5'd4);
      sender_idles  = 1'b0;
      rsp_hold_long = 1'b1;
      send_random_items(16);
      wait_drained();
      sender_idles = 1'b1;
   endtask

   // Walk through several dimension settings with mixed idling.
   task automatic test_random_phases();
      logic [DIM_W-1:0] dims [9] = '{5'd1, 5'd16, 5'd3, 5'd31, 5'd0,
                                     5'd17, 5'd9, 5'd16, 5'd6};
      dims[8] = 5'($urandom_range(2, 15));
      for (int p = 0; p < 9; p++) begin
         write_dimension(dims[p]);
         sender_idles   = (p % 4 == 0) || (p % 4 == 1);
         receiver_idles = (p % 4 == 0) || (p % 4 == 2);
         send_random_items(PHASE_ITEMS);
      end
      sender_idles   = 1'b1;
      receiver_idles = 1'b1;
   endtask

   // Pause the sender until everything has come back, then carry on.
   task automatic test_sender_pause();
      send_random_items(15);
      wait_drained();
      send_random_items(15);
   endtask

   initial begin : stimulus
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_reset_state();
      test_directed_moves();
      test_dimension_limits();
      test_result_backpressure();
      test_random_phases();
      test_sender_pause();
      wait_drained();
      $display("covered %0d moves, %0d loads, %0d reads, %0d rejected items",
               moves_applied, loads_applied, reads_applied, items_rejected);
      $display("%0d results checked over %0d dimension writes, %0d long stalls",
               results_checked, dim_writes, long_holds);
      if (mismatches == 0 && form_results_due.size() == 0) begin
         $display("tb OK");
      end else begin
         $display("tb NOT OK");
      end
      $finish;
   end

endmodule
